FILE: hdl/rri_pkg.sv
package rri_pkg;

    // field widths
    localparam int CW        = 20;
    localparam int FRAC      = 12;
    localparam int TW        = 24;
    localparam int DISTW     = 24;
    localparam int SZW       = 20;
    localparam int TEXW      = 13;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 3 * CW;

    // internal widths
    localparam int COW   = CW + 1;
    localparam int PW    = 2 * CW;
    localparam int NUMPW = COW + CW;
    localparam int DNW   = PW + 2;
    localparam int NUMW  = NUMPW + 2;
    localparam int DDW   = 2 * CW;
    localparam int NW    = NUMW + FRAC;
    localparam int QW    = TW + 1;
    localparam int DIVW  = DNW + QW;
    localparam int DTW   = CW + TW;
    localparam int PTW   = DTW - FRAC + 1;
    localparam int VW    = PTW + 1;
    localparam int VPW   = VW + CW;
    localparam int AW    = VPW + 2;
    localparam int PRODW = CW + 1 + TW;
    localparam int TQW   = TEXW;
    localparam int TRW   = SZW + TQW;
    localparam int L_TEX = TQW + 2;
    localparam int NST   = 3 + (QW + 1) + 6 + L_TEX;

    localparam logic signed [TW-1:0] T_MAX   = {1'b0, {(TW-1){1'b1}}};
    localparam logic signed [TW-1:0] T_MIN   = {1'b1, {(TW-1){1'b0}}};
    localparam logic [TEXW-1:0]      TEX_MID = TEXW'(2048);
    localparam logic [TEXW-1:0]      TEX_MAX = {TEXW{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER,
        REG_NORMAL,
        REG_TAN_U,
        REG_TAN_V,
        REG_SIZE_U,
        REG_SIZE_V,
        REG_BACK_ONLY
    } cfg_reg_t;

    typedef struct packed {
        logic [2:0][CW-1:0] o;
        logic [2:0][CW-1:0] d;
        logic [TW-1:0]      t_lo;
        logic [TW-1:0]      t_hi;
        logic [DISTW-1:0]   closest;
    } ray_t;

    // one step of the t divider and the norm square root
    typedef struct packed {
        ray_t            ray;
        logic            miss;
        logic            neg;
        logic            ovf;
        logic [NW-1:0]   rem;
        logic [DNW-1:0]  den;
        logic [QW-1:0]   q;
        logic [DDW-1:0]  sx;
        logic [DDW-1:0]  sr;
    } dv_t;

    // one step of the texture divider
    typedef struct packed {
        logic            neg;
        logic [TRW-1:0]  rem;
        logic [TQW-1:0]  q;
    } tdv_t;

    // result fields waiting for the texture coordinates
    typedef struct packed {
        logic               miss;
        logic [DISTW-1:0]   hd;
        logic [2:0][CW-1:0] p;
    } tl_t;

endpackage

FILE: hdl/rri_tex.sv
module rri_tex (
    input  logic                         clk,
    input  logic                         adv,
    input  logic signed [rri_pkg::AW-1:0] a,
    input  logic [rri_pkg::SZW-1:0]      size,
    output logic [rri_pkg::TEXW-1:0]     tex
);
    import rri_pkg::*;

    tdv_t            st_reg [TQW+1];
    tdv_t            st0_next;
    logic [TEXW-1:0] tex_reg;
    logic [TEXW-1:0] tex_next;

    // magnitude and sign of the projection
    always_comb
    begin : s0_comb
        logic [AW-1:0] mag;
        mag = a[AW-1] ? AW'(-a) : AW'(a);
        st0_next.neg = a[AW-1];
        st0_next.rem = mag[TRW-1:0];
        st0_next.q   = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0] <= st0_next;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar j = 1; j <= TQW; j++)
    begin : g_div
        localparam int K = TQW - j;
        tdv_t nx;

        always_comb
        begin
            logic [TRW-1:0] sub;
            sub = TRW'(size) << K;
            nx  = st_reg[j-1];
            if (st_reg[j-1].rem >= sub)
            begin
                nx.rem  = st_reg[j-1].rem - sub;
                nx.q[K] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_reg[j] <= nx;
            end
        end
    end

    // floor, recentre and clamp; a zero size gives the midpoint
    always_comb
    begin : fin_comb
        logic signed [TQW+1:0] qs;
        logic signed [TQW+1:0] u;
        qs = $signed({2'b00, st_reg[TQW].q});
        if (st_reg[TQW].neg)
        begin
            qs = (TQW+2)'(0) - qs - (TQW+2)'(|st_reg[TQW].rem);
        end
        u = qs + $signed({2'b00, TEX_MID});
        if (size == '0)
        begin
            tex_next = TEX_MID;
        end
        else if (u[TQW+1])
        begin
            tex_next = '0;
        end
        else if (u[TQW])
        begin
            tex_next = TEX_MAX;
        end
        else
        begin
            tex_next = u[TEXW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tex_reg <= tex_next;
        end
    end

    assign tex = tex_reg;

endmodule

FILE: hdl/ray_rectangle_intersect.sv
// Ray against rectangle test, one ray per cycle.
// Configure the rectangle on the cfg port (cfg_index selects center,
// normal, tangent u, tangent v, size u, size v, back_only); cfg_ready is
// always high and writes are meant for times when no ray is in flight.
// Rays enter on in_valid/in_stall; a transfer happens when in_valid is
// high and in_stall is low. Each ray gives exactly one result on
// out_valid/out_stall, in order. Throughput is one ray per cycle unless
// a result is stalled: the pipeline is 50 register stages, most of them
// taken by the bit-per-stage divider for t (25 quotient bits plus setup,
// with the norm square root alongside) and by the texture dividers (13
// quotient bits plus setup and finish).
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset clears all configuration registers to zero and empties the
// pipeline. A miss reports hit low with every other field zero.
module ray_rectangle_intersect (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [rri_pkg::CW-1:0]      origin_x,
    input  logic signed [rri_pkg::CW-1:0]      origin_y,
    input  logic signed [rri_pkg::CW-1:0]      origin_z,
    input  logic signed [rri_pkg::CW-1:0]      dir_x,
    input  logic signed [rri_pkg::CW-1:0]      dir_y,
    input  logic signed [rri_pkg::CW-1:0]      dir_z,
    input  logic signed [rri_pkg::TW-1:0]      t_lower,
    input  logic signed [rri_pkg::TW-1:0]      t_upper,
    input  logic [rri_pkg::DISTW-1:0]          closest_dist,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               hit,
    output logic [rri_pkg::DISTW-1:0]          hit_dist,
    output logic signed [rri_pkg::CW-1:0]      hit_x,
    output logic signed [rri_pkg::CW-1:0]      hit_y,
    output logic signed [rri_pkg::CW-1:0]      hit_z,
    output logic [rri_pkg::TEXW-1:0]           tex_u,
    output logic [rri_pkg::TEXW-1:0]           tex_v,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rri_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rri_pkg::CFG_W-1:0]          cfg_data
);
    import rri_pkg::*;

    logic adv;

    // configuration registers
    logic [CFG_W-1:0] center_reg;
    logic [CFG_W-1:0] normal_reg;
    logic [CFG_W-1:0] tan_u_reg;
    logic [CFG_W-1:0] tan_v_reg;
    logic [SZW-1:0]   size_u_reg;
    logic [SZW-1:0]   size_v_reg;
    logic             back_only_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg    <= '0;
            normal_reg    <= '0;
            tan_u_reg     <= '0;
            tan_v_reg     <= '0;
            size_u_reg    <= '0;
            size_v_reg    <= '0;
            back_only_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CENTER:    center_reg    <= cfg_data;
                REG_NORMAL:    normal_reg    <= cfg_data;
                REG_TAN_U:     tan_u_reg     <= cfg_data;
                REG_TAN_V:     tan_v_reg     <= cfg_data;
                REG_SIZE_U:    size_u_reg    <= cfg_data[SZW-1:0];
                REG_SIZE_V:    size_v_reg    <= cfg_data[SZW-1:0];
                REG_BACK_ONLY: back_only_reg <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // unpacked vectors
    logic signed [CW-1:0] c    [3];
    logic signed [CW-1:0] n    [3];
    logic signed [CW-1:0] tu   [3];
    logic signed [CW-1:0] tv   [3];
    logic signed [CW-1:0] in_o [3];
    logic signed [CW-1:0] in_d [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            c[i]  = center_reg[i*CW +: CW];
            n[i]  = normal_reg[i*CW +: CW];
            tu[i] = tan_u_reg[i*CW +: CW];
            tv[i] = tan_v_reg[i*CW +: CW];
        end
        in_o[0] = origin_x;
        in_o[1] = origin_y;
        in_o[2] = origin_z;
        in_d[0] = dir_x;
        in_d[1] = dir_y;
        in_d[2] = dir_z;
    end

    // valid bits travel alongside the stages
    logic [NST-1:0] vld_reg;

    assign out_valid = vld_reg[NST-1];
    assign adv       = !(out_valid && out_stall);
    assign in_stall  = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    // stage 1: center minus origin, first products
    ray_t                  r1_reg, r1_next;
    logic signed [COW-1:0] co1_reg   [3];
    logic signed [COW-1:0] co1_next  [3];
    logic signed [PW-1:0]  pdn1_reg  [3];
    logic signed [PW-1:0]  pdn1_next [3];
    logic [PW-1:0]         pdd1_reg  [3];
    logic [PW-1:0]         pdd1_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            r1_next.o[i] = in_o[i];
            r1_next.d[i] = in_d[i];
            co1_next[i]  = COW'(c[i]) - COW'(in_o[i]);
            pdn1_next[i] = in_d[i] * n[i];
            pdd1_next[i] = PW'(in_d[i] * in_d[i]);
        end
        r1_next.t_lo    = t_lower;
        r1_next.t_hi    = t_upper;
        r1_next.closest = closest_dist;
    end

    // stage 2: numerator products, d.n and d.d
    ray_t                    r2_reg;
    logic signed [NUMPW-1:0] pnum2_reg  [3];
    logic signed [NUMPW-1:0] pnum2_next [3];
    logic signed [DNW-1:0]   dn2_reg, dn2_next;
    logic [DDW-1:0]          dd2_reg, dd2_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pnum2_next[i] = co1_reg[i] * n[i];
        end
        dn2_next = DNW'(pdn1_reg[0]) + DNW'(pdn1_reg[1]) + DNW'(pdn1_reg[2]);
        dd2_next = DDW'(pdd1_reg[0]) + DDW'(pdd1_reg[1]) + DDW'(pdd1_reg[2]);
    end

    // stage 3: numerator sum, facing and parallel rejection
    ray_t                   r3_reg;
    logic signed [NUMW-1:0] num3_reg, num3_next;
    logic signed [DNW-1:0]  dn3_reg;
    logic [DDW-1:0]         dd3_reg;
    logic                   miss3_reg, miss3_next;

    always_comb
    begin
        num3_next = NUMW'(pnum2_reg[0]) + NUMW'(pnum2_reg[1]) + NUMW'(pnum2_reg[2]);
        miss3_next = (dn2_reg == '0)
                   || (back_only_reg && !dn2_reg[DNW-1] && (dn2_reg != '0));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_reg    <= r1_next;
            co1_reg   <= co1_next;
            pdn1_reg  <= pdn1_next;
            pdd1_reg  <= pdd1_next;
            r2_reg    <= r1_reg;
            pnum2_reg <= pnum2_next;
            dn2_reg   <= dn2_next;
            dd2_reg   <= dd2_next;
            r3_reg    <= r2_reg;
            num3_reg  <= num3_next;
            dn3_reg   <= dn2_reg;
            dd3_reg   <= dd2_reg;
            miss3_reg <= miss3_next;
        end
    end

    // divider setup: magnitudes, sign and overflow of t
    dv_t dv_reg [QW+1];
    dv_t dv0_next;

    always_comb
    begin : dv0_comb
        logic [NUMW-1:0] nmag;
        logic [DNW-1:0]  dmag;
        logic [NW-1:0]   nsh;
        nmag = num3_reg[NUMW-1] ? NUMW'(-num3_reg) : NUMW'(num3_reg);
        dmag = dn3_reg[DNW-1] ? DNW'(-dn3_reg) : DNW'(dn3_reg);
        nsh  = {nmag, {FRAC{1'b0}}};
        dv0_next.ray  = r3_reg;
        dv0_next.miss = miss3_reg;
        dv0_next.neg  = num3_reg[NUMW-1] ^ dn3_reg[DNW-1];
        dv0_next.ovf  = DIVW'(nsh) >= {dmag, {QW{1'b0}}};
        dv0_next.rem  = nsh;
        dv0_next.den  = dmag;
        dv0_next.q    = '0;
        dv0_next.sx   = dd3_reg;
        dv0_next.sr   = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_reg[0] <= dv0_next;
        end
    end

    // one quotient bit per stage; the first CW stages also give one root bit
    for (genvar j = 1; j <= QW; j++)
    begin : g_tdiv
        localparam int K     = QW - j;
        localparam bit DO_SQ = (j - 1) < CW;
        localparam int SSH   = DO_SQ ? 2 * (CW - j) : 0;
        dv_t nx;

        always_comb
        begin
            logic [DIVW-1:0] sub;
            logic [DDW-1:0]  bitv;
            logic [DDW:0]    trial;
            sub   = DIVW'(dv_reg[j-1].den) << K;
            bitv  = DDW'(1) << SSH;
            trial = {1'b0, dv_reg[j-1].sr} + {1'b0, bitv};
            nx    = dv_reg[j-1];
            if (DIVW'(dv_reg[j-1].rem) >= sub)
            begin
                nx.rem  = dv_reg[j-1].rem - sub[NW-1:0];
                nx.q[K] = 1'b1;
            end
            if (DO_SQ)
            begin
                if ({1'b0, dv_reg[j-1].sx} >= trial)
                begin
                    nx.sx = dv_reg[j-1].sx - trial[DDW-1:0];
                    nx.sr = (dv_reg[j-1].sr >> 1) + bitv;
                end
                else
                begin
                    nx.sr = dv_reg[j-1].sr >> 1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_reg[j] <= nx;
            end
        end
    end

    // t: sign, saturation and range test
    ray_t                 rt_reg;
    logic                 mt_reg, mt_next;
    logic signed [TW-1:0] tt_reg, tt_next;
    logic [CW-1:0]        nrm_reg;

    always_comb
    begin : t_comb
        logic [QW-1:0] q;
        logic          sat_pos;
        logic          sat_neg;
        q       = dv_reg[QW].q;
        sat_pos = dv_reg[QW].ovf | q[QW-1] | q[QW-2];
        sat_neg = dv_reg[QW].ovf | q[QW-1] | (q[QW-2] & (|q[QW-3:0]));
        if (dv_reg[QW].neg)
        begin
            tt_next = sat_neg ? T_MIN : $signed(TW'(0) - q[TW-1:0]);
        end
        else
        begin
            tt_next = sat_pos ? T_MAX : $signed(q[TW-1:0]);
        end
        mt_next = dv_reg[QW].miss
                || (tt_next < $signed(dv_reg[QW].ray.t_lo))
                || (tt_next > $signed(dv_reg[QW].ray.t_hi));
    end

    // products with t
    logic signed [PRODW-1:0] prod_reg, prod_next;
    logic signed [DTW-1:0]   dt_reg  [3];
    logic signed [DTW-1:0]   dt_next [3];
    logic [2:0][CW-1:0]      om_reg;
    logic [DISTW-1:0]        clm_reg;
    logic                    mm_reg;

    always_comb
    begin
        prod_next = $signed({1'b0, nrm_reg}) * tt_reg;
        for (int i = 0; i < 3; i++)
        begin
            dt_next[i] = $signed(rt_reg.d[i]) * tt_reg;
        end
    end

    // hit point, distance test and distance
    logic signed [PTW-1:0] p_reg  [3];
    logic signed [PTW-1:0] p_next [3];
    logic [DISTW-1:0]      hdp_reg, hdp_next;
    logic                  mp_reg, mp_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p_next[i] = PTW'($signed(om_reg[i])) + PTW'(dt_reg[i] >>> FRAC);
        end
        mp_next = mm_reg
               || (prod_reg > PRODW'($signed({1'b0, clm_reg, {FRAC{1'b0}}})));
        if (prod_reg[PRODW-1])
        begin
            hdp_next = '0;
        end
        else if (|prod_reg[PRODW-2:FRAC+DISTW])
        begin
            hdp_next = '1;
        end
        else
        begin
            hdp_next = prod_reg[FRAC+DISTW-1:FRAC];
        end
    end

    // offset from center, saturated hit point
    logic signed [VW-1:0] vec_reg  [3];
    logic signed [VW-1:0] vec_next [3];
    logic [2:0][CW-1:0]   ps_reg, ps_next;
    logic [DISTW-1:0]     hdv_reg;
    logic                 mv_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            vec_next[i] = VW'(p_reg[i]) - VW'(c[i]);
            if ((&p_reg[i][PTW-1:CW-1]) || !(|p_reg[i][PTW-1:CW-1]))
            begin
                ps_next[i] = p_reg[i][CW-1:0];
            end
            else if (p_reg[i][PTW-1])
            begin
                ps_next[i] = {1'b1, {(CW-1){1'b0}}};
            end
            else
            begin
                ps_next[i] = {1'b0, {(CW-1){1'b1}}};
            end
        end
    end

    // tangent products
    logic signed [VPW-1:0] pu_reg  [3];
    logic signed [VPW-1:0] pu_next [3];
    logic signed [VPW-1:0] pv_reg  [3];
    logic signed [VPW-1:0] pv_next [3];
    logic [2:0][CW-1:0]    psx_reg;
    logic [DISTW-1:0]      hdx_reg;
    logic                  mx_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pu_next[i] = vec_reg[i] * tu[i];
            pv_next[i] = vec_reg[i] * tv[i];
        end
    end

    // projections on the tangents
    logic signed [AW-1:0] au_reg, au_next;
    logic signed [AW-1:0] av_reg, av_next;
    logic [2:0][CW-1:0]   psa_reg;
    logic [DISTW-1:0]     hda_reg;
    logic                 ma_reg;

    always_comb
    begin
        au_next = AW'(pu_reg[0]) + AW'(pu_reg[1]) + AW'(pu_reg[2]);
        av_next = AW'(pv_reg[0]) + AW'(pv_reg[1]) + AW'(pv_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rt_reg   <= dv_reg[QW].ray;
            mt_reg   <= mt_next;
            tt_reg   <= tt_next;
            nrm_reg  <= dv_reg[QW].sr[CW-1:0];
            prod_reg <= prod_next;
            dt_reg   <= dt_next;
            om_reg   <= rt_reg.o;
            clm_reg  <= rt_reg.closest;
            mm_reg   <= mt_reg;
            p_reg    <= p_next;
            hdp_reg  <= hdp_next;
            mp_reg   <= mp_next;
            vec_reg  <= vec_next;
            ps_reg   <= ps_next;
            hdv_reg  <= hdp_reg;
            mv_reg   <= mp_reg;
            pu_reg   <= pu_next;
            pv_reg   <= pv_next;
            psx_reg  <= ps_reg;
            hdx_reg  <= hdv_reg;
            mx_reg   <= mv_reg;
            au_reg   <= au_next;
            av_reg   <= av_next;
            psa_reg  <= psx_reg;
            hda_reg  <= hdx_reg;
            ma_reg   <= mx_reg;
        end
    end

    // extent test, then wait for the texture dividers
    tl_t tl_reg [L_TEX];
    tl_t tl0_next;

    always_comb
    begin : ext_comb
        logic [AW-1:0] mag_u;
        logic [AW-1:0] mag_v;
        logic [AW-1:0] lim_u;
        logic [AW-1:0] lim_v;
        mag_u = au_reg[AW-1] ? AW'(-au_reg) : AW'(au_reg);
        mag_v = av_reg[AW-1] ? AW'(-av_reg) : AW'(av_reg);
        lim_u = AW'({size_u_reg, {(FRAC-1){1'b0}}}) + AW'(1);
        lim_v = AW'({size_v_reg, {(FRAC-1){1'b0}}}) + AW'(1);
        tl0_next.miss = ma_reg || (mag_u > lim_u) || (mag_v > lim_v);
        tl0_next.hd   = hda_reg;
        tl0_next.p    = psa_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tl_reg[0] <= tl0_next;
            for (int i = 1; i < L_TEX; i++)
            begin
                tl_reg[i] <= tl_reg[i-1];
            end
        end
    end

    logic [TEXW-1:0] tex_u_w;
    logic [TEXW-1:0] tex_v_w;

    rri_tex u_tex_u (
        .clk  (clk),
        .adv  (adv),
        .a    (au_reg),
        .size (size_u_reg),
        .tex  (tex_u_w)
    );

    rri_tex u_tex_v (
        .clk  (clk),
        .adv  (adv),
        .a    (av_reg),
        .size (size_v_reg),
        .tex  (tex_v_w)
    );

    // a miss reports all fields as zero
    assign hit      = !tl_reg[L_TEX-1].miss;
    assign hit_dist = hit ? tl_reg[L_TEX-1].hd : '0;
    assign hit_x    = hit ? tl_reg[L_TEX-1].p[0] : '0;
    assign hit_y    = hit ? tl_reg[L_TEX-1].p[1] : '0;
    assign hit_z    = hit ? tl_reg[L_TEX-1].p[2] : '0;
    assign tex_u    = hit ? tex_u_w : '0;
    assign tex_v    = hit ? tex_v_w : '0;

endmodule
